### sv/bvm_pkg.sv
`timescale 1ns / 1ps

package bvm_pkg;

    localparam int SampleW         = 12;
    localparam int SamplesPerBurst = 8;   // power of two: the average is a shift
    localparam int BurstBits       = $clog2(SamplesPerBurst);
    localparam int SumW            = SampleW + BurstBits;
    localparam int MvW             = 16;
    localparam int CfgW            = 12;
    localparam int CfgIdxW         = 8;
    localparam int PctW            = 7;
    localparam int SegW            = 13;  // widest segment product: 149 * 30

    localparam logic [CfgIdxW-1:0] CfgDividerGain = CfgIdxW'(0);
    localparam logic [CfgIdxW-1:0] CfgMaxSpread   = CfgIdxW'(1);

    localparam logic [CfgW-1:0] GainReset   = CfgW'(512);
    localparam logic [CfgW-1:0] SpreadReset = CfgW'(100);

    localparam logic [MvW-1:0] PlausibleLo = MvW'(3000);
    localparam logic [MvW-1:0] PlausibleHi = MvW'(4500);

    localparam logic [MvW-1:0] KneeFull = MvW'(4150);
    localparam logic [MvW-1:0] Knee85   = MvW'(4000);
    localparam logic [MvW-1:0] Knee60   = MvW'(3850);
    localparam logic [MvW-1:0] Knee30   = MvW'(3700);
    localparam logic [MvW-1:0] Knee10   = MvW'(3550);
    localparam logic [MvW-1:0] KneeEmpty = MvW'(3300);

    // floor(x / 150) == (x * Recip150) >> RecipShift for every x below 2^SegW
    localparam int RecipShift = 20;
    localparam int Recip150   = 6991;
    localparam int RecipW     = SegW + 13;

    typedef struct packed {
        logic [PctW-1:0] base;
        logic [SegW-1:0] x;     // offset into the segment times its slope numerator
    } t_lipo_seg;

    // Every segment slope is written as num / 150; the lowest one (10 / 250) is 6 / 150.
    function automatic t_lipo_seg lipo_segment(input logic [MvW-1:0] mv);
        logic [MvW-1:0] d;
        logic [4:0]     num;
        t_lipo_seg      s;
        d      = '0;
        num    = '0;
        s.base = '0;
        if (mv >= KneeFull) begin
            s.base = PctW'(100);
        end else if (mv >= Knee85) begin
            s.base = PctW'(85);
            d      = mv - Knee85;
            num    = 5'd15;
        end else if (mv >= Knee60) begin
            s.base = PctW'(60);
            d      = mv - Knee60;
            num    = 5'd25;
        end else if (mv >= Knee30) begin
            s.base = PctW'(30);
            d      = mv - Knee30;
            num    = 5'd30;
        end else if (mv >= Knee10) begin
            s.base = PctW'(10);
            d      = mv - Knee10;
            num    = 5'd20;
        end else if (mv >= KneeEmpty) begin
            d      = mv - KneeEmpty;
            num    = 5'd6;
        end
        s.x = SegW'(d[7:0]) * SegW'(num);
        return s;
    endfunction

    function automatic logic [PctW-1:0] lipo_finish(input t_lipo_seg s);
        logic [RecipW-1:0] p;
        p = RecipW'(s.x) * RecipW'(Recip150);
        return s.base + PctW'(p[RecipW-1:RecipShift]);
    endfunction

endpackage

### sv/battery_voltage_monitor.sv
`timescale 1ns / 1ps

// Battery voltage monitor.
// Input channel (i_in_valid / o_in_ready / i_sample_mv): one ADC pin reading per request.
// Every eighth sample closes a burst and yields one result on the output channel
// (o_out_valid / i_out_ready): scaled average, 1/8 IIR filtered voltage, LiPo charge
// percent and a presence flag. Other samples yield nothing.
// Config channel (i_cfg_valid / o_cfg_ready, always ready): index 0 divider gain (Q8),
// index 1 max burst spread; other indexes are ignored. Write only while idle.
// Throughput: one sample per cycle while o_in_ready holds. The burst accumulator takes a
// sample each such cycle, and a five-register pipeline (average/spread, gain multiply,
// filter, segment select, reciprocal multiply) moves one burst result per cycle unless stalled.
// Output: o_out_valid is the stage-five valid, set once a burst has passed stages one to four.
// Reset: accumulators cleared, filter unprimed, gain 512, spread 100, no results pending.
// Receiver stall: each stage holds until the next frees up; samples keep being accepted
// and only the closing sample of a burst waits when the pipeline is full.
module battery_voltage_monitor (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [bvm_pkg::SampleW-1:0] i_sample_mv,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [bvm_pkg::MvW-1:0]     o_burst_mv,
    output logic [bvm_pkg::MvW-1:0]     o_filtered_mv,
    output logic [bvm_pkg::PctW-1:0]    o_charge_percent,
    output logic                        o_present,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [bvm_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [bvm_pkg::CfgW-1:0]    i_cfg_data
);

    localparam logic [bvm_pkg::BurstBits-1:0] LastCount =
        bvm_pkg::BurstBits'(bvm_pkg::SamplesPerBurst - 1);
    localparam int ProdW = 2 * bvm_pkg::SampleW;
    localparam int FiltW = bvm_pkg::MvW + 3;

    logic [bvm_pkg::CfgW-1:0]      r_gain, r_max_spread;
    logic [bvm_pkg::SumW-1:0]      r_sum, n_sum;
    logic [bvm_pkg::SampleW-1:0]   r_min, n_min, r_max, n_max;
    logic [bvm_pkg::BurstBits-1:0] r_count;

    logic                          r_v1, r_v2, r_v3, r_v4, r_v5;
    logic [bvm_pkg::SampleW-1:0]   r_avg1;
    logic                          r_quiet1, r_quiet2;
    logic [bvm_pkg::MvW-1:0]       r_batt2, r_batt3, r_batt4;
    logic [bvm_pkg::MvW-1:0]       r_filter_value, r_filt4;
    logic                          r_primed, r_present3, r_present4;
    bvm_pkg::t_lipo_seg            r_seg4;

    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy5;
    logic w_accept, w_last;
    logic [bvm_pkg::SampleW-1:0]   w_spread;
    logic [ProdW-1:0]              w_prod;
    logic [FiltW-1:0]              w_filt_sum;
    logic [bvm_pkg::MvW-1:0]       n_filter;

    assign w_rdy5 = !r_v5 || i_out_ready;
    assign w_rdy4 = !r_v4 || w_rdy5;
    assign w_rdy3 = !r_v3 || w_rdy4;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;

    assign w_last     = (r_count == LastCount);
    assign o_in_ready = !w_last || w_rdy1;
    assign w_accept   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_sum = r_sum + bvm_pkg::SumW'(i_sample_mv);
        n_min = (i_sample_mv < r_min) ? i_sample_mv : r_min;
        n_max = (i_sample_mv > r_max) ? i_sample_mv : r_max;
    end

    assign w_spread = n_max - n_min;

    // 4095 * 4095 >> 8 stays below 65535, so the Q8 product never saturates
    assign w_prod = r_avg1 * r_gain;

    assign w_filt_sum = (FiltW'(r_filter_value) << 3) - FiltW'(r_filter_value)
                      + FiltW'(r_batt2);
    assign n_filter   = r_primed ? w_filt_sum[FiltW-1:3] : r_batt2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain       <= bvm_pkg::GainReset;
            r_max_spread <= bvm_pkg::SpreadReset;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bvm_pkg::CfgDividerGain: r_gain       <= i_cfg_data;
                bvm_pkg::CfgMaxSpread:   r_max_spread <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_min   <= '1;
            r_max   <= '0;
            r_count <= '0;
        end else if (w_accept) begin
            if (w_last) begin
                r_sum   <= '0;
                r_min   <= '1;
                r_max   <= '0;
                r_count <= '0;
            end else begin
                r_sum   <= n_sum;
                r_min   <= n_min;
                r_max   <= n_max;
                r_count <= r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_filter_value <= '0;
            r_primed       <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= w_accept && w_last;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
            if (w_rdy5) r_v5 <= r_v4;
            if (w_rdy3 && r_v2) begin
                r_filter_value <= n_filter;
                r_primed       <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && w_accept && w_last) begin
            r_avg1   <= n_sum[bvm_pkg::SumW-1:bvm_pkg::BurstBits];
            r_quiet1 <= (w_spread <= r_max_spread);
        end
        if (w_rdy2 && r_v1) begin
            r_batt2  <= w_prod[ProdW-1:8];
            r_quiet2 <= r_quiet1;
        end
        if (w_rdy3 && r_v2) begin
            r_batt3    <= r_batt2;
            r_present3 <= r_quiet2 && (n_filter >= bvm_pkg::PlausibleLo)
                                   && (n_filter <= bvm_pkg::PlausibleHi);
        end
        if (w_rdy4 && r_v3) begin
            r_batt4    <= r_batt3;
            r_filt4    <= r_filter_value;
            r_present4 <= r_present3;
            r_seg4     <= bvm_pkg::lipo_segment(r_filter_value);
        end
        if (w_rdy5 && r_v4) begin
            o_burst_mv       <= r_batt4;
            o_filtered_mv    <= r_filt4;
            o_present        <= r_present4;
            o_charge_percent <= bvm_pkg::lipo_finish(r_seg4);
        end
    end

    assign o_out_valid = r_v5;

    a_present_plausible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_present |->
            (o_filtered_mv >= bvm_pkg::PlausibleLo) && (o_filtered_mv <= bvm_pkg::PlausibleHi))
        else $error("present flagged with implausible filtered voltage");

    a_burst_enters_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_last |=> r_v1)
        else $error("closing sample accepted but no burst entered the pipeline");

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> (r_min <= r_max))
        else $error("burst minimum above burst maximum");

    a_percent_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_charge_percent <= bvm_pkg::PctW'(100)))
        else $error("charge percent above 100");

endmodule
